### sv/rtp_pkg.sv
package rtp_pkg;

    // register reset values and the record size used when the register is zero
    localparam logic [15:0] DEFAULT_RECORD_SIZE = 16'd128;
    localparam logic [15:0] SECTOR_SIZE_RESET   = 16'd512;
    localparam logic [2:0]  CLUSTER_SHIFT_RESET = 3'd0;

    // restoring divide steps, one per cell, for a 32-bit dividend
    localparam int DIV_STEPS = 32;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RECORD_SIZE   = 2'd0,
        CFG_SECTOR_SIZE   = 2'd1,
        CFG_CLUSTER_SHIFT = 2'd2
    } cfg_index_t;

    // partial remainder plus combined dividend / quotient shift word
    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] dq;
    } div_state_t;

    // carried alongside the byte position divide
    typedef struct packed {
        logic [31:0] byte_pos;
        logic [31:0] total;
        logic        eof;
    } div_a_side_t;

    // carried alongside the remaining byte count divide
    typedef struct packed {
        logic [31:0] byte_pos;
        logic [15:0] sec;
        logic [15:0] off;
        logic [15:0] clus;
        logic [15:0] first;
        logic        eof;
    } div_b_side_t;

endpackage

### sv/rtp_div_cell.sv
module rtp_div_cell
    import rtp_pkg::*;
#(
    parameter int SIDE_W = 65
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       ssize,
    input  logic              prev_valid,
    input  div_state_t        prev_div,
    input  logic [SIDE_W-1:0] prev_side,
    output logic              take,
    input  logic              next_take,
    output logic              valid_reg,
    output div_state_t        div_reg,
    output logic [SIDE_W-1:0] side_reg
);

    logic [16:0] shifted;
    logic [16:0] diff;
    logic        fits;
    div_state_t  div_next;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted      = {prev_div.rem, prev_div.dq[31]};
        diff         = shifted - {1'b0, ssize};
        fits         = (shifted >= {1'b0, ssize});
        div_next.rem = fits ? diff[15:0] : shifted[15:0];
        div_next.dq  = {prev_div.dq[30:0], fits};
    end

    // slot loads when empty or when the neighbor downstream takes its item
    assign take = !valid_reg || next_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && prev_valid)
        begin
            div_reg  <= div_next;
            side_reg <= prev_side;
        end
    end

endmodule

### sv/rtp_front.sv
module rtp_front
    import rtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] rsize,
    input  logic        in_valid,
    input  logic [31:0] record_position,
    input  logic [15:0] record_count,
    input  logic        is_write,
    input  logic [31:0] file_size,
    output logic        take,
    input  logic        next_take,
    output logic        valid_reg,
    output div_state_t  div_reg,
    output div_a_side_t side_reg
);

    logic        mul_valid_reg;
    logic [31:0] mul_pos_reg;
    logic [31:0] mul_total_reg;
    logic        mul_write_reg;
    logic [31:0] mul_fsize_reg;
    logic [47:0] pos_product;
    logic        trim_take;
    logic        past_end;
    logic [31:0] left;
    logic [31:0] total_trim;

    // stage 1: byte position and requested byte count
    assign pos_product = record_position * rsize;
    assign take        = !mul_valid_reg || trim_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            mul_pos_reg   <= pos_product[31:0];
            mul_total_reg <= {16'd0, record_count} * {16'd0, rsize};
            mul_write_reg <= is_write;
            mul_fsize_reg <= file_size;
        end
    end

    // stage 2: end-of-file check and trim for reads
    always_comb
    begin
        past_end   = (mul_fsize_reg <= mul_pos_reg);
        left       = mul_fsize_reg - mul_pos_reg;
        total_trim = mul_total_reg;
        if (!mul_write_reg && !past_end && (left < mul_total_reg))
        begin
            total_trim = left;
        end
    end

    assign trim_take = !valid_reg || next_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (trim_take)
        begin
            valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (trim_take && mul_valid_reg)
        begin
            div_reg.rem       <= 16'd0;
            div_reg.dq        <= mul_pos_reg;
            side_reg.byte_pos <= mul_pos_reg;
            side_reg.total    <= total_trim;
            side_reg.eof      <= !mul_write_reg && past_end;
        end
    end

endmodule

### sv/rtp_mid.sv
module rtp_mid
    import rtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] ssize,
    input  logic [2:0]  cluster_shift,
    input  logic        prev_valid,
    input  div_state_t  prev_div,
    input  div_a_side_t prev_side,
    output logic        take,
    input  logic        next_take,
    output logic        valid_reg,
    output div_state_t  div_reg,
    output div_b_side_t side_reg
);

    logic [15:0] sec;
    logic [15:0] room;
    logic [15:0] first;
    logic [31:0] remain;
    div_state_t  div_next;
    div_b_side_t side_next;

    // leading partial sector, clamped to the full remaining count
    always_comb
    begin
        sec   = prev_div.dq[15:0];
        room  = ssize - prev_div.rem;
        first = 16'd0;
        if (prev_div.rem != 16'd0)
        begin
            first = (prev_side.total < {16'd0, room}) ? prev_side.total[15:0] : room;
        end
        remain = prev_side.total - {16'd0, first};

        side_next.byte_pos = prev_side.byte_pos;
        side_next.eof      = prev_side.eof;
        side_next.sec      = sec;
        side_next.off      = prev_div.rem;
        side_next.clus     = sec >> cluster_shift;
        side_next.first    = first;
        div_next.rem       = 16'd0;
        div_next.dq        = remain;

        // end of file: only the byte position and the end-of-file flag survive
        if (prev_side.eof)
        begin
            side_next.sec   = 16'd0;
            side_next.off   = 16'd0;
            side_next.clus  = 16'd0;
            side_next.first = 16'd0;
            div_next.dq     = 32'd0;
        end
    end

    assign take = !valid_reg || next_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && prev_valid)
        begin
            div_reg  <= div_next;
            side_reg <= side_next;
        end
    end

endmodule

### sv/record_transfer_planner_top.sv
// Record transfer planner.
// Input channel (in_valid / in_stall): record_position, record_count, is_write
// and file_size. A transaction completes on an edge with in_valid high and
// in_stall low. Output channel (out_valid / out_stall): one plan per request,
// in order, held steady while out_stall is high.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
// record_size, sector_size and cluster_shift; cfg_ready is always high. Write
// only while no request is in flight.
// It takes one request per cycle while out_stall is low and has 67 register
// stages: the two 32-cell restoring divide chains (byte position / sector
// size, then remaining bytes / sector size), plus a multiply stage, a trim
// stage and a split stage between the chains.
// Every stage is a slot that loads when empty or when its neighbor moves, so
// while out_stall is high the chain fills up and then raises in_stall; bubbles
// close up meanwhile.
// Reset empties the pipeline and loads 128 / 512 / 0 into the registers.
module record_transfer_planner_top
    import rtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] record_position,
    input  logic [15:0] record_count,
    input  logic        is_write,
    input  logic [31:0] file_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [31:0] byte_position,
    output logic [15:0] sector_index,
    output logic [15:0] offset_in_sector,
    output logic [15:0] cluster_index,
    output logic [15:0] first_bytes,
    output logic [15:0] whole_sectors,
    output logic [15:0] last_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] record_size_reg;
    logic [15:0] sector_size_reg;
    logic [2:0]  cluster_shift_reg;
    logic [15:0] rsize;
    logic [15:0] ssize;
    logic        front_take;
    logic        mid_take;

    logic        a_valid [0:DIV_STEPS];
    div_state_t  a_div   [0:DIV_STEPS];
    div_a_side_t a_side  [0:DIV_STEPS];
    logic        a_take  [0:DIV_STEPS-1];
    logic        b_valid [0:DIV_STEPS];
    div_state_t  b_div   [0:DIV_STEPS];
    div_b_side_t b_side  [0:DIV_STEPS];
    logic        b_take  [0:DIV_STEPS-1];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_size_reg   <= DEFAULT_RECORD_SIZE;
            sector_size_reg   <= SECTOR_SIZE_RESET;
            cluster_shift_reg <= CLUSTER_SHIFT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RECORD_SIZE:   record_size_reg   <= cfg_data;
                CFG_SECTOR_SIZE:   sector_size_reg   <= cfg_data;
                CFG_CLUSTER_SHIFT: cluster_shift_reg <= cfg_data[2:0];
                default:           ;
            endcase
        end
    end

    // zero record size means the default, zero sector size acts as one
    assign rsize = (record_size_reg == 16'd0) ? DEFAULT_RECORD_SIZE : record_size_reg;
    assign ssize = (sector_size_reg == 16'd0) ? 16'd1 : sector_size_reg;

    // multiply and trim
    rtp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .rsize           (rsize),
        .in_valid        (in_valid),
        .record_position (record_position),
        .record_count    (record_count),
        .is_write        (is_write),
        .file_size       (file_size),
        .take            (front_take),
        .next_take       (a_take[0]),
        .valid_reg       (a_valid[0]),
        .div_reg         (a_div[0]),
        .side_reg        (a_side[0])
    );

    assign in_stall = !front_take;

    // byte position divide chain
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_chain_a
        logic next_take_k;
        if (k == DIV_STEPS - 1)
        begin : g_last
            assign next_take_k = mid_take;
        end
        else
        begin : g_inner
            assign next_take_k = a_take[k+1];
        end

        rtp_div_cell #(
            .SIDE_W ($bits(div_a_side_t))
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ssize      (ssize),
            .prev_valid (a_valid[k]),
            .prev_div   (a_div[k]),
            .prev_side  (a_side[k]),
            .take       (a_take[k]),
            .next_take  (next_take_k),
            .valid_reg  (a_valid[k+1]),
            .div_reg    (a_div[k+1]),
            .side_reg   (a_side[k+1])
        );
    end

    // sector split between the chains
    rtp_mid u_mid (
        .clk           (clk),
        .rst_n         (rst_n),
        .ssize         (ssize),
        .cluster_shift (cluster_shift_reg),
        .prev_valid    (a_valid[DIV_STEPS]),
        .prev_div      (a_div[DIV_STEPS]),
        .prev_side     (a_side[DIV_STEPS]),
        .take          (mid_take),
        .next_take     (b_take[0]),
        .valid_reg     (b_valid[0]),
        .div_reg       (b_div[0]),
        .side_reg      (b_side[0])
    );

    // remaining bytes divide chain; its last cell is the output register
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_chain_b
        logic next_take_k;
        if (k == DIV_STEPS - 1)
        begin : g_last
            assign next_take_k = !out_stall;
        end
        else
        begin : g_inner
            assign next_take_k = b_take[k+1];
        end

        rtp_div_cell #(
            .SIDE_W ($bits(div_b_side_t))
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ssize      (ssize),
            .prev_valid (b_valid[k]),
            .prev_div   (b_div[k]),
            .prev_side  (b_side[k]),
            .take       (b_take[k]),
            .next_take  (next_take_k),
            .valid_reg  (b_valid[k+1]),
            .div_reg    (b_div[k+1]),
            .side_reg   (b_side[k+1])
        );
    end

    // result fields
    assign out_valid        = b_valid[DIV_STEPS];
    assign status           = b_side[DIV_STEPS].eof;
    assign byte_position    = b_side[DIV_STEPS].byte_pos;
    assign sector_index     = b_side[DIV_STEPS].sec;
    assign offset_in_sector = b_side[DIV_STEPS].off;
    assign cluster_index    = b_side[DIV_STEPS].clus;
    assign first_bytes      = b_side[DIV_STEPS].first;
    assign whole_sectors    = b_div[DIV_STEPS].dq[15:0];
    assign last_bytes       = b_div[DIV_STEPS].rem;

endmodule

### sv/rtp_checker.sv
module rtp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        status,
    input logic [31:0] byte_position,
    input logic [15:0] sector_index,
    input logic [15:0] offset_in_sector,
    input logic [15:0] cluster_index,
    input logic [15:0] first_bytes,
    input logic [15:0] whole_sectors,
    input logic [15:0] last_bytes
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_position) && $stable(status))
        else $error("stalled result changed");

    // end of file plans carry no sector breakdown
    a_eof_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> sector_index == 16'd0 && offset_in_sector == 16'd0
            && first_bytes == 16'd0 && whole_sectors == 16'd0 && last_bytes == 16'd0)
        else $error("end of file result with nonzero plan");

    // a sector-aligned start has no leading partial sector
    a_aligned_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status && offset_in_sector == 16'd0 |-> first_bytes == 16'd0)
        else $error("aligned start with leading bytes");

    // cluster index, the sector index shifted down, never exceeds the sector index
    a_cluster_le_sector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cluster_index <= sector_index)
        else $error("cluster index above sector index");

endmodule

bind record_transfer_planner_top rtp_checker u_rtp_checker (.*);
